// File: hw/rtl/cpa_pkg.sv
// Shared types, codes and helpers for the confidence predictor arbiter.
package cpa_pkg;

  localparam int unsigned MaskBits = 8;
  localparam int unsigned ConfBits = 8;
  localparam int unsigned IdxBits  = 3;
  localparam int unsigned CfgBits  = 4;

  typedef enum logic {
    OP_CHOOSE = 1'b0,
    OP_UPDATE = 1'b1
  } op_e;

  typedef struct packed {
    op_e                 opcode;
    logic [MaskBits-1:0] spec_mask;
    logic [MaskBits-1:0] offered_mask;
    logic [MaskBits-1:0] correct_mask;
  } in_t;

  typedef struct packed {
    logic                chosen_valid;
    logic [IdxBits-1:0]  chosen_child;
    logic [ConfBits-1:0] chosen_confidence;
  } out_t;

  // Per-lane command from the top level to one counter lane.
  typedef struct packed {
    logic                upd_en;
    logic                correct;
    logic                clamp_en;
    logic [ConfBits-1:0] cnt_max;
  } lane_cmd_t;

  // Saturation maximum for a counter width; widths below one act as one,
  // widths above eight act as eight.
  function automatic logic [ConfBits-1:0] counter_max(input logic [CfgBits-1:0] bits);
    logic [CfgBits-1:0] b;
    logic [15:0]        full;
    b = bits;
    if (b == '0) b = CfgBits'(1);
    if (b > CfgBits'(ConfBits)) b = CfgBits'(ConfBits);
    full = (16'(1) << b) - 16'(1);
    return full[ConfBits-1:0];
  endfunction

endpackage

// File: hw/rtl/cpa_lane.sv
// One saturating confidence counter lane.
module cpa_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cpa_pkg::lane_cmd_t                  cmd_i,
  output logic [cpa_pkg::ConfBits-1:0]        conf_o
);
  import cpa_pkg::*;

  logic [ConfBits-1:0] conf_q, conf_d;

  always_comb begin
    conf_d = conf_q;
    if (cmd_i.clamp_en) begin
      if (conf_q > cmd_i.cnt_max) conf_d = cmd_i.cnt_max;
    end else if (cmd_i.upd_en) begin
      if (cmd_i.correct) begin
        if (conf_q < cmd_i.cnt_max) conf_d = conf_q + ConfBits'(1);
      end else begin
        if (conf_q != '0) conf_d = conf_q - ConfBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conf_q <= '0;
    end else begin
      conf_q <= conf_d;
    end
  end

  assign conf_o = conf_q;

endmodule

// File: hw/rtl/cpa_merge.sv
// Pairwise maximum tree that picks the requesting lane with the highest counter.
module cpa_merge #(
  parameter int unsigned NumLanes = 8
) (
  input  logic [NumLanes-1:0]                         req_i,
  input  logic [NumLanes-1:0][cpa_pkg::ConfBits-1:0]  conf_i,
  output cpa_pkg::out_t                               result_o
);
  import cpa_pkg::*;

  localparam int unsigned Levels = IdxBits;
  localparam int unsigned Leaves = 1 << Levels;

  logic [Leaves-1:0]               vld;
  logic [Leaves-1:0][ConfBits-1:0] cnf;
  logic [Leaves-1:0][IdxBits-1:0]  idx;

  always_comb begin
    for (int i = 0; i < Leaves; i++) begin
      if (i < NumLanes) begin
        vld[i] = req_i[i];
        cnf[i] = conf_i[i];
      end else begin
        vld[i] = 1'b0;
        cnf[i] = '0;
      end
      idx[i] = IdxBits'(i);
    end
    // The left entry always holds the lower indices, so it wins a tie.
    for (int l = 0; l < Levels; l++) begin
      for (int p = 0; p < (Leaves >> (l + 1)); p++) begin
        if (!vld[2*p] || (vld[2*p+1] && (cnf[2*p+1] > cnf[2*p]))) begin
          vld[p] = vld[2*p+1];
          cnf[p] = cnf[2*p+1];
          idx[p] = idx[2*p+1];
        end else begin
          vld[p] = vld[2*p];
          cnf[p] = cnf[2*p];
          idx[p] = idx[2*p];
        end
      end
    end
    result_o.chosen_valid      = vld[0];
    result_o.chosen_child      = vld[0] ? idx[0] : '0;
    result_o.chosen_confidence = vld[0] ? cnf[0] : '0;
  end

endmodule

// File: hw/rtl/confidence_predictor_arbiter.sv
// Top level of the confidence predictor arbiter.
// Keeps one saturating confidence counter per child predictor, one lane each, and answers
// a choose item with the spec-mask child of highest counter (lowest index on ties) or
// updates the counters of the children that offered. One item is taken per cycle while
// input is not stalled, and its result is written to the output register on the transfer;
// that register is the only stage; input is stalled only while a result there is stalled.
// Counter width is set by the cfg write; a write clamps every counter to the new maximum.
module confidence_predictor_arbiter #(
  parameter int unsigned CHILD_COUNT = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  cpa_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output cpa_pkg::out_t                out_data_o,
  input  logic                         cfg_we_i,
  input  logic [cpa_pkg::CfgBits-1:0]  cfg_wdata_i
);
  import cpa_pkg::*;

  localparam int unsigned NumLanes = (CHILD_COUNT < MaskBits) ? CHILD_COUNT : MaskBits;

  logic [ConfBits-1:0]               cnt_max_q;
  logic [ConfBits-1:0]               cfg_max;
  logic                              in_xfer;
  logic                              out_valid_q;
  out_t                              out_data_q;
  out_t                              pick;
  logic [NumLanes-1:0]               choose_req;
  logic [NumLanes-1:0][ConfBits-1:0] lane_conf;
  lane_cmd_t [NumLanes-1:0]          lane_cmd;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign cfg_max    = counter_max(cfg_wdata_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_max_q <= counter_max(CfgBits'(2));
    end else if (cfg_we_i) begin
      cnt_max_q <= cfg_max;
    end
  end

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    assign lane_cmd[g].upd_en   = in_xfer && (in_data_i.opcode == OP_UPDATE)
                                  && in_data_i.offered_mask[g];
    assign lane_cmd[g].correct  = in_data_i.correct_mask[g];
    assign lane_cmd[g].clamp_en = cfg_we_i;
    assign lane_cmd[g].cnt_max  = cfg_we_i ? cfg_max : cnt_max_q;
    assign choose_req[g]        = in_data_i.spec_mask[g];

    cpa_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (lane_cmd[g]),
      .conf_o (lane_conf[g])
    );
  end

  cpa_merge #(
    .NumLanes (NumLanes)
  ) u_merge (
    .req_i    (choose_req),
    .conf_i   (lane_conf),
    .result_o (pick)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= (in_data_i.opcode == OP_UPDATE) ? out_t'('0) : pick;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled while the output register is empty");

  a_xfer_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_o)
    else $error("accepted item produced no result");

  a_update_no_choice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (in_data_i.opcode == OP_UPDATE)) |=> !out_data_o.chosen_valid)
    else $error("update item returned a choice");

  a_no_choice_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.chosen_valid) |->
      (out_data_o.chosen_child == '0 && out_data_o.chosen_confidence == '0))
    else $error("empty result carries nonzero fields");
`endif

endmodule
